[src/bic_pkg.sv]
// Shared types and constants of the BPSK I/Q correlator.
package bic_pkg;

    // Configuration port and register layout.
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PHASE_BITS     = 32;
    localparam int LEN_BITS       = 9;
    localparam int GAIN_BITS      = 18;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_OFFSET  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYMBOL_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUMP_GAIN     = 2'd3;

    localparam logic [LEN_BITS-1:0]  SYMBOL_LENGTH_RESET = 9'd4;
    localparam logic [GAIN_BITS-1:0] DUMP_GAIN_RESET     = 18'd32768;

    // Result format.
    localparam int OUT_BITS = 17;
    localparam logic [OUT_BITS-1:0] OUT_MAX_VALUE = 17'h0FFFF;
    localparam logic [OUT_BITS-1:0] OUT_MIN_VALUE = 17'h10000;

    // Quarter-wave sine polynomial, all in Q16; U_BITS holds 0..65536.
    localparam int FRAC_BITS = 16;
    localparam int U_BITS    = 17;
    localparam logic [U_BITS-1:0] U_FULL = 17'h10000;
    localparam logic [U_BITS-1:0] POLY_A = 17'd102944;
    localparam logic [U_BITS-1:0] POLY_B = 17'd42334;
    localparam logic [U_BITS-1:0] POLY_C = 17'd5223;
    localparam logic [U_BITS-1:0] POLY_D = 17'd307;
    localparam logic [U_BITS-1:0] POLY_E = 17'd10;
    localparam int TRIG_ROUND_HALF = 32768;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQUARE,
        OP_HORNER0,
        OP_HORNER1,
        OP_HORNER2,
        OP_HORNER3,
        OP_HORNER4,
        OP_TRIG,
        OP_MAC_I,
        OP_MAC_Q,
        OP_ACC_Q,
        OP_DUMP_LOAD,
        OP_DUMP_MUL,
        OP_DUMP_SUM,
        OP_DUMP_ROUND
    } bic_op_t;

    // Command word from controller to datapath.
    typedef struct packed {
        bic_op_t op;
        logic    sel_cos;
        logic    sel_q;
        logic    load_in;
        logic    load_out;
    } bic_cmd_t;

endpackage

[src/bic_datapath.sv]
// Datapath: configuration, carrier phase, shared multiplier, sums and dump scaling.
module bic_datapath #(
    parameter int SAMPLE_BITS       = 16,
    parameter int TRIG_BITS         = 16,
    parameter int TABLE_ADDR_BITS   = 10,
    parameter int MAX_SYMBOL_LENGTH = 256,
    parameter int MUL_BITS          = 18,
    parameter int ACC_BITS          = 40,
    parameter int NCHUNK            = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bic_pkg::bic_cmd_t                     cmd,
    output logic                                  dump_due,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    output logic        [bic_pkg::OUT_BITS-1:0]   in_phase_data,
    output logic        [bic_pkg::OUT_BITS-1:0]   quadrature_data,
    input  logic                                  cfg_write,
    input  logic        [bic_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [bic_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bic_pkg::*;

    localparam int QB        = TABLE_ADDR_BITS - 2;
    localparam int CNT_BITS  = $clog2(MAX_SYMBOL_LENGTH + 1);
    localparam int CMP_BITS  = (CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int PMAG_BITS = SAMPLE_BITS + TRIG_BITS - 1;
    localparam int MAG_BITS  = NCHUNK * MUL_BITS;
    localparam int PW        = MAG_BITS + MUL_BITS;
    localparam int SH        = 15 + TRIG_BITS;
    localparam int RES_MIN   = OUT_BITS + 1;
    localparam int SUMW      = (PW + 1 > SH + RES_MIN) ? PW + 1 : SH + RES_MIN;
    localparam int RW        = SUMW - SH;
    localparam int VW        = U_BITS + TRIG_BITS;

    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER  = TABLE_ADDR_BITS'(1) << QB;
    localparam logic [TRIG_BITS:0]         TRIG_LIM = (TRIG_BITS+1)'((2 ** (TRIG_BITS - 1)) - 1);
    localparam logic [CMP_BITS-1:0]        LEN_MAX  = CMP_BITS'(MAX_SYMBOL_LENGTH);
    localparam logic [CMP_BITS-1:0]        LEN_ONE  = CMP_BITS'(1);
    localparam logic [RW-1:0]              RES_POS_LIM = RW'(OUT_MAX_VALUE);
    localparam logic [RW-1:0]              RES_NEG_LIM = RW'(OUT_MIN_VALUE);

    // Configuration and running state.
    logic [PHASE_BITS-1:0]      phase_step_reg;
    logic [PHASE_BITS-1:0]      phase_offset_reg;
    logic [LEN_BITS-1:0]        symbol_length_reg;
    logic [GAIN_BITS-1:0]       dump_gain_reg;
    logic [PHASE_BITS-1:0]      carrier_phase_reg;
    logic [CNT_BITS-1:0]        count_reg;
    logic [ACC_BITS-1:0]        acc_i_reg;
    logic [ACC_BITS-1:0]        acc_q_reg;

    // Working registers.
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [TABLE_ADDR_BITS-1:0] addr_reg;
    logic [PROD_BITS-1:0]       prod_reg;
    logic                       prod_neg_reg;
    logic [U_BITS-1:0]          u2_reg;
    logic [TRIG_BITS-1:0]       sin_reg;
    logic [TRIG_BITS-1:0]       cos_reg;
    logic [MAG_BITS-1:0]        mag_reg;
    logic                       neg_reg;
    logic [PW-1:0]              p_reg;
    logic [OUT_BITS-1:0]        res_i_reg;
    logic [OUT_BITS-1:0]        res_q_reg;
    logic [OUT_BITS-1:0]        in_phase_reg;
    logic [OUT_BITS-1:0]        quadrature_reg;

    logic [PHASE_BITS-1:0]      angle;
    logic [TABLE_ADDR_BITS-1:0] trig_addr;
    logic [1:0]                 quad;
    logic [U_BITS-1:0]          frac;
    logic [U_BITS-1:0]          u_val;
    logic [U_BITS-1:0]          prod_hi;
    logic [U_BITS-1:0]          coef;
    logic [U_BITS-1:0]          t_val;
    logic [VW-1:0]              trig_tmp;
    logic [TRIG_BITS:0]         trig_round;
    logic [TRIG_BITS:0]         trig_cap;
    logic [TRIG_BITS-1:0]       trig_val;
    logic [SAMPLE_BITS-1:0]     s_mag;
    logic [TRIG_BITS-1:0]       cos_mag;
    logic [TRIG_BITS-1:0]       sin_mag;
    logic [MUL_BITS-1:0]        mul_a;
    logic [MUL_BITS-1:0]        mul_b;
    logic [PROD_BITS-1:0]       product;
    logic [ACC_BITS-1:0]        prod_acc;
    logic [ACC_BITS-1:0]        dump_src;
    logic [ACC_BITS-1:0]        dump_mag;
    logic [SUMW-1:0]            sum_round;
    logic [RW-1:0]              res_mag;
    logic [OUT_BITS-1:0]        res_val;
    logic [CMP_BITS-1:0]        len_wide;
    logic [CMP_BITS-1:0]        len_eff;

    // Effective symbol length and dump decision.
    always_comb
    begin
        len_wide = CMP_BITS'(symbol_length_reg);
        if (len_wide == '0)
        begin
            len_eff = LEN_ONE;
        end
        else if (len_wide > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = len_wide;
        end
    end

    assign dump_due = CMP_BITS'(count_reg) >= len_eff;

    // Angle of the incoming sample.
    assign angle = carrier_phase_reg + phase_offset_reg;

    // Quadrant folding of the table address into the polynomial argument.
    assign trig_addr = cmd.sel_cos ? (addr_reg + QUARTER) : addr_reg;
    assign quad      = trig_addr[TABLE_ADDR_BITS-1 -: 2];
    assign frac      = U_BITS'(trig_addr[QB-1:0]) << (FRAC_BITS - QB);
    assign u_val     = quad[0] ? (U_FULL - frac) : frac;
    assign prod_hi   = prod_reg[FRAC_BITS +: U_BITS];

    // Horner coefficient for the current step.
    always_comb
    begin
        case (cmd.op)
            OP_HORNER1: coef = POLY_D;
            OP_HORNER2: coef = POLY_C;
            OP_HORNER3: coef = POLY_B;
            OP_HORNER4: coef = POLY_A;
            default:    coef = '0;
        endcase
    end

    assign t_val = coef - prod_hi;

    // Conversion of the Q16 sine to the trig format, capped and signed.
    assign trig_tmp   = (VW'(prod_hi) << (TRIG_BITS - 1)) + VW'(TRIG_ROUND_HALF);
    assign trig_round = trig_tmp[VW-1:FRAC_BITS];
    assign trig_cap   = (trig_round > TRIG_LIM) ? TRIG_LIM : trig_round;
    assign trig_val   = quad[1] ? (-trig_cap[TRIG_BITS-1:0]) : trig_cap[TRIG_BITS-1:0];

    // Magnitudes for the sign-magnitude multiplier.
    assign s_mag   = sample_reg[SAMPLE_BITS-1] ? (-sample_reg) : sample_reg;
    assign cos_mag = cos_reg[TRIG_BITS-1] ? (-cos_reg) : cos_reg;
    assign sin_mag = sin_reg[TRIG_BITS-1] ? (-sin_reg) : sin_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = MUL_BITS'(u_val);
                mul_b = MUL_BITS'(u_val);
            end
            OP_HORNER0:
            begin
                mul_a = MUL_BITS'(prod_hi);
                mul_b = MUL_BITS'(POLY_E);
            end
            OP_HORNER1, OP_HORNER2, OP_HORNER3:
            begin
                mul_a = MUL_BITS'(u2_reg);
                mul_b = MUL_BITS'(t_val);
            end
            OP_HORNER4:
            begin
                mul_a = MUL_BITS'(u_val);
                mul_b = MUL_BITS'(t_val);
            end
            OP_MAC_I:
            begin
                mul_a = MUL_BITS'(s_mag);
                mul_b = MUL_BITS'(cos_mag);
            end
            OP_MAC_Q:
            begin
                mul_a = MUL_BITS'(s_mag);
                mul_b = MUL_BITS'(sin_mag);
            end
            OP_DUMP_MUL:
            begin
                mul_a = mag_reg[MAG_BITS-1 -: MUL_BITS];
                mul_b = MUL_BITS'(dump_gain_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign product  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign prod_acc = ACC_BITS'(prod_reg[PMAG_BITS-1:0]);

    // Sum selected for dump, as sign and magnitude.
    assign dump_src = cmd.sel_q ? acc_q_reg : acc_i_reg;
    assign dump_mag = dump_src[ACC_BITS-1] ? (-dump_src) : dump_src;

    // Rounding of the scaled sum and saturation to the result range.
    assign sum_round = SUMW'(p_reg) + (SUMW'(1) << (SH - 1));
    assign res_mag   = sum_round[SUMW-1:SH];

    always_comb
    begin
        if (neg_reg)
        begin
            res_val = (res_mag > RES_NEG_LIM) ? OUT_MIN_VALUE : (-res_mag[OUT_BITS-1:0]);
        end
        else
        begin
            res_val = (res_mag > RES_POS_LIM) ? OUT_MAX_VALUE : res_mag[OUT_BITS-1:0];
        end
    end

    // Configuration, phase, sample count and the two sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= '0;
            phase_offset_reg  <= '0;
            symbol_length_reg <= SYMBOL_LENGTH_RESET;
            dump_gain_reg     <= DUMP_GAIN_RESET;
            carrier_phase_reg <= '0;
            count_reg         <= '0;
            acc_i_reg         <= '0;
            acc_q_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PHASE_STEP:    phase_step_reg    <= cfg_data[PHASE_BITS-1:0];
                    CFG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data[PHASE_BITS-1:0];
                    CFG_SYMBOL_LENGTH: symbol_length_reg <= cfg_data[LEN_BITS-1:0];
                    CFG_DUMP_GAIN:     dump_gain_reg     <= cfg_data[GAIN_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_in)
            begin
                carrier_phase_reg <= carrier_phase_reg + phase_step_reg;
                count_reg         <= count_reg + CNT_BITS'(1);
            end
            if (cmd.op == OP_MAC_Q)
            begin
                acc_i_reg <= prod_neg_reg ? (acc_i_reg - prod_acc) : (acc_i_reg + prod_acc);
            end
            if (cmd.op == OP_ACC_Q)
            begin
                acc_q_reg <= prod_neg_reg ? (acc_q_reg + prod_acc) : (acc_q_reg - prod_acc);
            end
            if (cmd.load_out)
            begin
                acc_i_reg <= '0;
                acc_q_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    // Working registers of the multiply sequence and the result registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        if (cmd.load_in)
        begin
            sample_reg <= sample_value;
            addr_reg   <= angle[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        end
        case (cmd.op)
            OP_HORNER0:
            begin
                u2_reg <= prod_hi;
            end
            OP_TRIG:
            begin
                if (cmd.sel_cos)
                begin
                    cos_reg <= trig_val;
                end
                else
                begin
                    sin_reg <= trig_val;
                end
            end
            OP_MAC_I:
            begin
                prod_neg_reg <= sample_reg[SAMPLE_BITS-1] ^ cos_reg[TRIG_BITS-1];
            end
            OP_MAC_Q:
            begin
                prod_neg_reg <= sample_reg[SAMPLE_BITS-1] ^ sin_reg[TRIG_BITS-1];
            end
            OP_DUMP_LOAD:
            begin
                mag_reg <= MAG_BITS'(dump_mag);
                neg_reg <= dump_src[ACC_BITS-1];
                p_reg   <= '0;
            end
            OP_DUMP_MUL:
            begin
                p_reg   <= (p_reg << MUL_BITS) + PW'(prod_reg);
                mag_reg <= mag_reg << MUL_BITS;
            end
            OP_DUMP_SUM:
            begin
                p_reg <= (p_reg << MUL_BITS) + PW'(prod_reg);
            end
            OP_DUMP_ROUND:
            begin
                if (cmd.sel_q)
                begin
                    res_q_reg <= res_val;
                end
                else
                begin
                    res_i_reg <= res_val;
                end
            end
            default:
            begin
            end
        endcase
        if (cmd.load_out)
        begin
            in_phase_reg   <= res_i_reg;
            quadrature_reg <= res_q_reg;
        end
    end

    assign in_phase_data   = in_phase_reg;
    assign quadrature_data = quadrature_reg;

endmodule

[src/bic_ctrl.sv]
// Controller: sequences the shared multiplier per sample and per symbol dump.
module bic_ctrl #(
    parameter int NCHUNK = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  logic              dump_due,
    output bic_pkg::bic_cmd_t cmd
);
    import bic_pkg::*;

    localparam int CHUNK_BITS = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_HORNER0,
        S_HORNER1,
        S_HORNER2,
        S_HORNER3,
        S_HORNER4,
        S_TRIG,
        S_MAC_I,
        S_MAC_Q,
        S_ACC_Q,
        S_DUMP_LOAD,
        S_DUMP_MUL,
        S_DUMP_SUM,
        S_DUMP_ROUND,
        S_OUTPUT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  cos_pass_reg;
    logic                  cos_pass_next;
    logic                  q_pass_reg;
    logic                  q_pass_next;
    logic [CHUNK_BITS-1:0] chunk_reg;
    logic [CHUNK_BITS-1:0] chunk_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_take;
    logic                  out_load;
    bic_op_t               op;

    // Input is taken only between samples; the output slot frees on a transaction.
    assign sample_stall = (state_reg != S_IDLE);
    assign in_take      = sample_valid && (state_reg == S_IDLE);
    assign out_load     = (state_reg == S_OUTPUT) && (!out_valid_reg || !result_stall);

    // Datapath operation for each state.
    always_comb
    begin
        case (state_reg)
            S_SQUARE:     op = OP_SQUARE;
            S_HORNER0:    op = OP_HORNER0;
            S_HORNER1:    op = OP_HORNER1;
            S_HORNER2:    op = OP_HORNER2;
            S_HORNER3:    op = OP_HORNER3;
            S_HORNER4:    op = OP_HORNER4;
            S_TRIG:       op = OP_TRIG;
            S_MAC_I:      op = OP_MAC_I;
            S_MAC_Q:      op = OP_MAC_Q;
            S_ACC_Q:      op = OP_ACC_Q;
            S_DUMP_LOAD:  op = OP_DUMP_LOAD;
            S_DUMP_MUL:   op = OP_DUMP_MUL;
            S_DUMP_SUM:   op = OP_DUMP_SUM;
            S_DUMP_ROUND: op = OP_DUMP_ROUND;
            default:      op = OP_NONE;
        endcase
    end

    always_comb
    begin
        cmd.op       = op;
        cmd.sel_cos  = cos_pass_reg;
        cmd.sel_q    = q_pass_reg;
        cmd.load_in  = in_take;
        cmd.load_out = out_load;
    end

    // Next state: sine pass, cosine pass, two products, then optional dump of I and Q.
    always_comb
    begin
        state_next    = state_reg;
        cos_pass_next = cos_pass_reg;
        q_pass_next   = q_pass_reg;
        chunk_next    = chunk_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next    = S_SQUARE;
                    cos_pass_next = 1'b0;
                end
            end
            S_SQUARE:  state_next = S_HORNER0;
            S_HORNER0: state_next = S_HORNER1;
            S_HORNER1: state_next = S_HORNER2;
            S_HORNER2: state_next = S_HORNER3;
            S_HORNER3: state_next = S_HORNER4;
            S_HORNER4: state_next = S_TRIG;
            S_TRIG:
            begin
                if (cos_pass_reg)
                begin
                    state_next = S_MAC_I;
                end
                else
                begin
                    cos_pass_next = 1'b1;
                    state_next    = S_SQUARE;
                end
            end
            S_MAC_I: state_next = S_MAC_Q;
            S_MAC_Q: state_next = S_ACC_Q;
            S_ACC_Q:
            begin
                if (dump_due)
                begin
                    q_pass_next = 1'b0;
                    state_next  = S_DUMP_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_LOAD:
            begin
                chunk_next = CHUNK_BITS'(NCHUNK - 1);
                state_next = S_DUMP_MUL;
            end
            S_DUMP_MUL:
            begin
                if (chunk_reg == '0)
                begin
                    state_next = S_DUMP_SUM;
                end
                else
                begin
                    chunk_next = chunk_reg - CHUNK_BITS'(1);
                end
            end
            S_DUMP_SUM: state_next = S_DUMP_ROUND;
            S_DUMP_ROUND:
            begin
                if (q_pass_reg)
                begin
                    state_next = S_OUTPUT;
                end
                else
                begin
                    q_pass_next = 1'b1;
                    state_next  = S_DUMP_LOAD;
                end
            end
            S_OUTPUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cos_pass_reg  <= 1'b0;
            q_pass_reg    <= 1'b0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cos_pass_reg  <= cos_pass_next;
            q_pass_reg    <= q_pass_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

[src/bpsk_iq_correlator_core.sv]
// Top level of the coherent BPSK I/Q integrate-and-dump correlator.
//
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sample_value
// result    out        result_valid / result_stall  in_phase, quadrature
// config    in         cfg_write                    cfg_index, cfg_data
//
// A sample runs two 7-step sine evaluations and three multiply-accumulate steps, all
// through one shared multiplier. A sample that closes a symbol then scales both sums,
// each by a load, a multiply step per chunk, a sum step and a rounding step.
// Reset clears the carrier phase, the sums, the count and the output valid flag.
// A stalled result waits in the output register; the next sample is still taken and
// only a following dump waits for the register to empty.
module bpsk_iq_correlator_core #(
    parameter int SAMPLE_BITS       = 16,
    parameter int TRIG_BITS         = 16,
    parameter int TABLE_ADDR_BITS   = 10,
    parameter int MAX_SYMBOL_LENGTH = 256
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      sample_valid,
    output logic                                      sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]             sample_value,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic signed [bic_pkg::OUT_BITS-1:0]       in_phase,
    output logic signed [bic_pkg::OUT_BITS-1:0]       quadrature,
    input  logic                                      cfg_write,
    input  logic        [bic_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [bic_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bic_pkg::*;

    localparam int MUL_WIDE = (SAMPLE_BITS > TRIG_BITS) ? SAMPLE_BITS : TRIG_BITS;
    localparam int MUL_BITS = (MUL_WIDE > GAIN_BITS) ? MUL_WIDE : GAIN_BITS;
    localparam int ACC_BITS = SAMPLE_BITS + TRIG_BITS + $clog2(MAX_SYMBOL_LENGTH);
    localparam int NCHUNK   = (ACC_BITS + MUL_BITS - 1) / MUL_BITS;

    bic_cmd_t            cmd;
    logic                dump_due;
    logic [OUT_BITS-1:0] in_phase_data;
    logic [OUT_BITS-1:0] quadrature_data;

    // Sequencer.
    bic_ctrl #(
        .NCHUNK (NCHUNK)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .dump_due     (dump_due),
        .cmd          (cmd)
    );

    // Arithmetic and storage.
    bic_datapath #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .TRIG_BITS         (TRIG_BITS),
        .TABLE_ADDR_BITS   (TABLE_ADDR_BITS),
        .MAX_SYMBOL_LENGTH (MAX_SYMBOL_LENGTH),
        .MUL_BITS          (MUL_BITS),
        .ACC_BITS          (ACC_BITS),
        .NCHUNK            (NCHUNK)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dump_due        (dump_due),
        .sample_value    (sample_value),
        .in_phase_data   (in_phase_data),
        .quadrature_data (quadrature_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    assign in_phase   = in_phase_data;
    assign quadrature = quadrature_data;

endmodule

[verif/tb_bpsk_iq_correlator_core.sv]
// Self-checking testbench for the BPSK I/Q correlator core: directed table, then random symbols.
module tb_bpsk_iq_correlator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bic_pkg::*;

    // Block sizes as instantiated.
    localparam int SAMPLE_W = 16;
    localparam int TRIG_W   = 16;
    localparam int ADDR_W   = 10;
    localparam int MAX_LEN  = 256;

    // Quarter-wave sine polynomial coefficients, Q16.
    localparam longint unsigned SINE_A = 102944;
    localparam longint unsigned SINE_B = 42334;
    localparam longint unsigned SINE_C = 5223;
    localparam longint unsigned SINE_D = 307;
    localparam longint unsigned SINE_E = 10;

    // Result saturation limits.
    localparam longint RESULT_HI = 65535;
    localparam longint RESULT_LO = -65536;

    // Run shaping.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 900;

    typedef logic signed [OUT_BITS-1:0] result_t;

    typedef struct {
        result_t i_val;
        result_t q_val;
    } dump_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [CFG_INDEX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]    data;
        logic signed [SAMPLE_W-1:0]  smp;
        bit                          typed;
        dump_t                       want;
    } row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         sample_valid;
    logic                         sample_stall;
    logic signed [SAMPLE_W-1:0]   sample_value;
    logic                         result_valid;
    logic                         result_stall;
    result_t                      in_phase;
    result_t                      quadrature;
    logic                         cfg_write;
    logic [CFG_INDEX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]     cfg_data;

    // Predictor copy of the registers and the running state.
    bit [31:0]        nco_step;
    bit [31:0]        nco_offset;
    bit [31:0]        nco_phase;
    bit [LEN_BITS-1:0]  len_reg;
    bit [GAIN_BITS-1:0] gain_reg;
    longint           i_sum;
    longint           q_sum;
    bit [LEN_BITS-1:0]  count;

    dump_t symbol_dumps_q[$];
    row_t  directed_rows[$];
    int    fail_count;
    int    send_idle_pct;
    int    stall_pct;

    always #10 clk = ~clk;

    bpsk_iq_correlator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .in_phase     (in_phase),
        .quadrature   (quadrature),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Sine of a table address in Q1.15, from the quarter-wave polynomial.
    function automatic longint carrier_sine(bit [ADDR_W-1:0] addr);
        bit [1:0]        quad;
        longint unsigned frac;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned r;
        longint unsigned v;
        longint unsigned cap;
        quad = addr[ADDR_W-1 -: 2];
        frac = longint'(addr[ADDR_W-3:0]) << (16 - (ADDR_W - 2));
        u    = quad[0] ? 64'd65536 - frac : frac;
        u2   = (u * u) >> 16;
        t    = SINE_E;
        t    = SINE_D - ((u2 * t) >> 16);
        t    = SINE_C - ((u2 * t) >> 16);
        t    = SINE_B - ((u2 * t) >> 16);
        t    = SINE_A - ((u2 * t) >> 16);
        r    = (u * t) >> 16;
        v    = ((r << (TRIG_W - 1)) + 64'd32768) >> 16;
        cap  = (64'd1 << (TRIG_W - 1)) - 64'd1;
        if (v > cap)
        begin
            v = cap;
        end
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    // Scale a symbol sum by the dump gain, round half away from zero, saturate.
    function automatic result_t dump_scale(longint acc);
        bit              neg;
        longint unsigned mag;
        longint unsigned r;
        longint          v;
        neg = acc < 0;
        mag = neg ? longint'(-acc) : longint'(acc);
        if (gain_reg != 0 && mag > (64'h7FFF_FFFF_FFFF_FFFF / gain_reg))
        begin
            r = 64'd1 << 20;
        end
        else
        begin
            r = (mag * gain_reg + (64'd1 << (14 + TRIG_W))) >> (15 + TRIG_W);
            if (r > (64'd1 << 20))
            begin
                r = 64'd1 << 20;
            end
        end
        v = neg ? -longint'(r) : longint'(r);
        if (v > RESULT_HI)
        begin
            v = RESULT_HI;
        end
        if (v < RESULT_LO)
        begin
            v = RESULT_LO;
        end
        return v[OUT_BITS-1:0];
    endfunction

    // Symbol length as the block uses it: zero acts as one, large values clamp.
    function automatic int effective_length();
        if (len_reg == 0)
        begin
            return 1;
        end
        if (len_reg > MAX_LEN)
        begin
            return MAX_LEN;
        end
        return int'(len_reg);
    endfunction

    // Correlate one sample against the carrier; returns 1 when the symbol dumps.
    function automatic bit correlate_sample(logic signed [SAMPLE_W-1:0] smp, output dump_t res);
        longint            s;
        longint            c;
        longint            sn;
        bit [31:0]         angle;
        bit [ADDR_W-1:0]   addr;
        s     = longint'(smp);
        angle = nco_phase + nco_offset;
        addr  = angle[31 -: ADDR_W];
        c     = carrier_sine(addr + ADDR_W'(1 << (ADDR_W - 2)));
        sn    = carrier_sine(addr);
        i_sum = i_sum + s * c;
        q_sum = q_sum - s * sn;
        nco_phase = nco_phase + nco_step;
        count = count + 1'b1;
        res = '{i_val: '0, q_val: '0};
        if (count >= effective_length())
        begin
            res.i_val = dump_scale(i_sum);
            res.q_val = dump_scale(q_sum);
            i_sum = 0;
            q_sum = 0;
            count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Directed table builders.
    function automatic void add_write(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.data  = data;
        r.smp   = '0;
        r.typed = 1'b0;
        r.want  = '{i_val: '0, q_val: '0};
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_sample(int smp);
        row_t r;
        r.kind  = ROW_SAMPLE;
        r.idx   = '0;
        r.data  = '0;
        r.smp   = smp[SAMPLE_W-1:0];
        r.typed = 1'b0;
        r.want  = '{i_val: '0, q_val: '0};
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_checked(int smp, int iv, int qv);
        row_t r;
        r.kind  = ROW_SAMPLE;
        r.idx   = '0;
        r.data  = '0;
        r.smp   = smp[SAMPLE_W-1:0];
        r.typed = 1'b1;
        r.want  = '{i_val: iv[OUT_BITS-1:0], q_val: qv[OUT_BITS-1:0]};
        directed_rows = {directed_rows, r};
    endfunction

    // Offer one sample, wait for the transaction, then queue what it should produce.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] v, bit typed, dump_t want);
        dump_t res;
        dump_t queued;
        bit    dumps;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            sample_value <= SAMPLE_W'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        dumps = correlate_sample(v, res);
        if (dumps || typed)
        begin
            if (typed)
            begin
                queued = want;
            end
            else
            begin
                queued = res;
            end
            symbol_dumps_q = {symbol_dumps_q, queued};
        end
    endtask

    // Let every pending symbol drain and the last sample finish inside the block.
    task automatic wait_quiet();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (symbol_dumps_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is quiet and mirror it in the predictor.
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:    nco_step   = data;
            CFG_PHASE_OFFSET:  nco_offset = data;
            CFG_SYMBOL_LENGTH: len_reg    = data[LEN_BITS-1:0];
            CFG_DUMP_GAIN:     gain_reg   = data[GAIN_BITS-1:0];
            default:           ;
        endcase
    endtask

    // Result side: random stall and comparison against the oldest pending symbol.
    always @(posedge clk)
    begin
        dump_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (symbol_dumps_q.size() == 0)
                begin
                    $error("unexpected result transaction: in_phase %0d quadrature %0d",
                           in_phase, quadrature);
                    fail_count++;
                end
                else
                begin
                    want = symbol_dumps_q.pop_front();
                    if (in_phase !== want.i_val)
                    begin
                        $error("in_phase: expected %0d, actual %0d", want.i_val, in_phase);
                        fail_count++;
                    end
                    if (quadrature !== want.q_val)
                    begin
                        $error("quadrature: expected %0d, actual %0d", want.q_val, quadrature);
                        fail_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stimulus.
    initial
    begin
        dump_t                       none;
        logic signed [SAMPLE_W-1:0]  v;
        logic [31:0]                 data;
        bit [31:0]                   angle;
        longint                      c;
        bit                          tx_negative;
        int                          random_items;
        int                          phase;
        int                          n_items;
        int                          eff;
        int                          pick;
        int                          amp;
        int                          level;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_value <= '0;
        result_stall <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;

        none          = '{i_val: '0, q_val: '0};
        fail_count    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        tx_negative   = 1'b0;
        random_items  = 0;
        nco_step   = '0;
        nco_offset = '0;
        nco_phase  = '0;
        len_reg    = 9'd4;
        gain_reg   = 18'd32768;
        i_sum      = 0;
        q_sum      = 0;
        count      = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // After reset the carrier sits at zero phase: cos is full scale, sin is zero.
        repeat (3) add_sample(32767);
        add_checked(32767, 65532, 0);
        // A gain of 131072 drives both signs into saturation.
        add_write(CFG_DUMP_GAIN, 32'd131072);
        repeat (3) add_sample(32767);
        add_checked(32767, 65535, 0);
        repeat (3) add_sample(-32768);
        add_checked(-32768, -65536, 0);
        // Zero gain, and a zero symbol length that dumps on every sample.
        add_write(CFG_DUMP_GAIN, 32'd0);
        add_write(CFG_SYMBOL_LENGTH, 32'd0);
        add_checked(12345, 0, 0);
        // A quarter-turn offset moves all energy into the quadrature arm.
        add_write(CFG_DUMP_GAIN, 32'd32768);
        add_write(CFG_PHASE_OFFSET, 32'h4000_0000);
        add_checked(32767, 0, -16383);
        // Running carrier, top offset, length written with junk above its field.
        add_write(CFG_PHASE_STEP, 32'h1234_5678);
        add_write(CFG_PHASE_OFFSET, 32'hFFFF_FFFF);
        add_write(CFG_SYMBOL_LENGTH, 32'hFFFF_FE03);
        add_sample(-32768);
        add_sample(32767);
        add_sample(16'h5A5A);
        // Length lowered in the middle of a symbol dumps on the next sample.
        add_write(CFG_SYMBOL_LENGTH, 32'd8);
        add_sample(1000);
        add_sample(-20000);
        add_sample(32767);
        add_sample(-1);
        add_sample(16'h1234);
        add_write(CFG_SYMBOL_LENGTH, 32'd2);
        add_sample(-7777);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_WRITE)
            begin
                write_register(directed_rows[k].idx, directed_rows[k].data);
            end
            else
            begin
                send_sample(directed_rows[k].smp, directed_rows[k].typed,
                            directed_rows[k].want);
            end
        end

        // Random phases: new settings, then a run of modulated and raw samples.
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase

            if ($urandom_range(1))
            begin
                pick = $urandom_range(4);
                case (pick)
                    0: data = 32'd0;
                    1: data = 32'hFFFF_FFFF;
                    2: data = $urandom;
                    3: data = $urandom_range(32'h0100_0000);
                    default: data = 32'h4000_0000;
                endcase
                write_register(CFG_PHASE_STEP, data);
            end
            if ($urandom_range(1))
            begin
                pick = $urandom_range(2);
                case (pick)
                    0: data = 32'd0;
                    1: data = 32'hFFFF_FFFF;
                    default: data = $urandom;
                endcase
                write_register(CFG_PHASE_OFFSET, data);
            end
            if ($urandom_range(1))
            begin
                pick = $urandom_range(23);
                case (pick)
                    0: data = 32'd0;
                    1: data = MAX_LEN;
                    2: data = $urandom_range(511, MAX_LEN + 1);
                    default: data = $urandom_range(8, 1);
                endcase
                if ($urandom_range(3) == 0)
                begin
                    data[31:LEN_BITS] = (32 - LEN_BITS)'($urandom);
                end
                write_register(CFG_SYMBOL_LENGTH, data);
            end
            if ($urandom_range(1))
            begin
                pick = $urandom_range(5);
                case (pick)
                    0: data = 32'd0;
                    1: data = 32'd131072;
                    2: data = 32'h3FFFF;
                    3: data = 131072 / effective_length();
                    default: data = $urandom_range(131072);
                endcase
                if ($urandom_range(3) == 0)
                begin
                    data[31:GAIN_BITS] = (32 - GAIN_BITS)'($urandom);
                end
                write_register(CFG_DUMP_GAIN, data);
            end

            eff = effective_length();
            if (eff > 16)
            begin
                n_items = eff + $urandom_range(eff / 2);
            end
            else
            begin
                n_items = $urandom_range(60, 10);
            end
            if (n_items > RANDOM_ITEMS - random_items)
            begin
                n_items = RANDOM_ITEMS - random_items;
            end

            repeat (n_items)
            begin
                // Mostly a noisy BPSK carrier, with raw words and extremes mixed in.
                angle = nco_phase + nco_offset;
                c = carrier_sine(angle[31 -: ADDR_W] + ADDR_W'(1 << (ADDR_W - 2)));
                if (count == 0)
                begin
                    tx_negative = 1'($urandom_range(1));
                end
                pick = $urandom_range(19);
                if (pick < 12)
                begin
                    amp   = $urandom_range(32767, 4096);
                    level = (tx_negative ? -int'(c) : int'(c)) * amp / 32768
                            + int'($urandom_range(1023)) - 512;
                    if (level > 32767)
                    begin
                        level = 32767;
                    end
                    if (level < -32768)
                    begin
                        level = -32768;
                    end
                    v = level[SAMPLE_W-1:0];
                end
                else if (pick < 17)
                begin
                    v = SAMPLE_W'($urandom);
                end
                else
                begin
                    case ($urandom_range(3))
                        0: v = 16'sh7FFF;
                        1: v = 16'sh8000;
                        2: v = 16'sh0000;
                        default: v = 16'shFFFF;
                    endcase
                end
                send_sample(v, 1'b0, none);
                random_items++;
            end
            phase++;
        end

        wait_quiet();
        if (fail_count == 0)
        begin
            $display("tb_bpsk_iq_correlator_core: clean");
        end
        else
        begin
            $display("tb_bpsk_iq_correlator_core: errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("tb_bpsk_iq_correlator_core: errors");
        $finish;
    end

endmodule

[bpsk_iq_correlator_core.f]
src/bic_pkg.sv
src/bic_datapath.sv
src/bic_ctrl.sv
src/bpsk_iq_correlator_core.sv
verif/tb_bpsk_iq_correlator_core.sv
